/* sv/mfbp_pkg.sv */
// shared types and constants for the midi file byte parser
`default_nettype none
package mfbp_pkg;

  typedef enum logic [3:0] {
    PH_HID, PH_HLEN, PH_HFMT, PH_HREST, PH_TID, PH_TLEN, PH_DELTA, PH_STATUS,
    PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_SLEN, PH_PAYLOAD, PH_DONE
  } phase_e;

  localparam logic [2:0] EV_HEADER  = 3'd0;
  localparam logic [2:0] EV_TSTART  = 3'd1;
  localparam logic [2:0] EV_CHAN    = 3'd2;
  localparam logic [2:0] EV_META    = 3'd3;
  localparam logic [2:0] EV_SYSEX   = 3'd4;
  localparam logic [2:0] EV_PAYLOAD = 3'd5;
  localparam logic [2:0] EV_TEND    = 3'd6;
  localparam logic [2:0] EV_ERROR   = 3'd7;

  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_MTHD    = 4'd1;
  localparam logic [3:0] ERR_HLEN    = 4'd2;
  localparam logic [3:0] ERR_FORMAT  = 4'd3;
  localparam logic [3:0] ERR_MTRK    = 4'd4;
  localparam logic [3:0] ERR_SYSEX   = 4'd5;
  localparam logic [3:0] ERR_STATUS  = 4'd6;
  localparam logic [3:0] ERR_RUNNING = 4'd7;
  localparam logic [3:0] ERR_OVERRUN = 4'd8;

  localparam logic [31:0] ID_HEADER = 32'h4D546864;
  localparam logic [31:0] ID_TRACK  = 32'h4D54726B;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [31:0] len;
    logic        fmt;
    logic [15:0] tracks;
    logic [15:0] division;
    logic        plast;
    logic [3:0]  err;
    logic        last;
  } result_t;

  // one data byte for program change and channel pressure
  function automatic logic one_data(input logic [7:0] st);
    return (st[6:4] == 3'd4) || (st[6:4] == 3'd5);
  endfunction

endpackage
`default_nettype wire

/* sv/mfbp_core.sv */
// parser state and per-byte decode, producing up to two results
`default_nettype none
module mfbp_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       byte_i,
  output mfbp_pkg::result_t     r0_o,
  output mfbp_pkg::result_t     r1_o,
  output logic [1:0]            nres_o
);
  import mfbp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] clen_q, clen_d, seen_q, seen_d, tick_q, tick_d;
  logic [7:0]  run_q, run_d, cur_q, cur_d, held_q, held_d;
  logic [27:0] prem_q, prem_d;
  logic [15:0] trk_q, trk_d;
  logic        err_q, err_d;

  logic [31:0] fx, vl, seen_inc;
  logic [2:0]  cnt_inc;
  logic        vdone, in_chunk, errs;
  result_t     r0, r1;
  logic [1:0]  n;

  always_comb begin
    fx = {shift_q[23:0], byte_i};
    vl = {4'd0, shift_q[20:0], byte_i[6:0]};
    vdone = !byte_i[7];
    cnt_inc = cnt_q + 3'd1;
    in_chunk = phase_q >= PH_DELTA && phase_q <= PH_PAYLOAD;
    seen_inc = seen_q + 32'd1;
  end

  always_comb begin
    phase_d = phase_q; shift_d = shift_q; cnt_d = cnt_q; clen_d = clen_q;
    seen_d = in_chunk ? seen_inc : seen_q;
    tick_d = tick_q; run_d = run_q; cur_d = cur_q; held_d = held_q;
    prem_d = prem_q; trk_d = trk_q; err_d = err_q; errs = 1'b0;
    r0 = '0; r1 = '0; n = 2'd0;
    if (take_i && !err_q) begin
      unique case (phase_q)
        PH_HID, PH_TID, PH_HLEN, PH_HFMT, PH_HREST, PH_TLEN: begin
          shift_d = fx; cnt_d = cnt_inc;
          if (cnt_inc >= ((phase_q == PH_HFMT) ? 3'd2 : 3'd4)) begin
            shift_d = '0; cnt_d = '0;
            unique case (phase_q)
              PH_HID: if (fx != ID_HEADER) begin
                r0.kind = EV_ERROR; r0.tick = tick_q; r0.err = ERR_MTHD; n = 2'd1;
                errs = 1'b1;
              end else phase_d = PH_HLEN;
              PH_TID: if (fx != ID_TRACK) begin
                r0.kind = EV_ERROR; r0.tick = tick_q; r0.err = ERR_MTRK; n = 2'd1;
                errs = 1'b1;
              end else phase_d = PH_TLEN;
              PH_HLEN: if (fx != 32'd6) begin
                r0.kind = EV_ERROR; r0.tick = tick_q; r0.err = ERR_HLEN; n = 2'd1;
                errs = 1'b1;
              end else phase_d = PH_HFMT;
              PH_HFMT: if (fx[15:0] > 16'd1) begin
                r0.kind = EV_ERROR; r0.tick = tick_q; r0.err = ERR_FORMAT; n = 2'd1;
                errs = 1'b1;
              end else begin
                held_d = {7'd0, fx[0]}; phase_d = PH_HREST;
              end
              PH_HREST: begin
                trk_d = fx[31:16];
                r0.kind = EV_HEADER; r0.fmt = held_q[0];
                r0.tracks = fx[31:16]; r0.division = fx[15:0]; n = 2'd1;
                held_d = '0;
                phase_d = (fx[31:16] != '0) ? PH_TID : PH_DONE;
              end
              default: begin
                clen_d = fx; seen_d = '0; tick_d = '0; run_d = '0;
                r0.kind = EV_TSTART; r0.len = fx; n = 2'd1;
                phase_d = PH_DELTA;
                if (fx == '0) begin
                  r1.kind = EV_TEND; n = 2'd2;
                  trk_d = trk_q - 16'd1;
                  phase_d = (trk_q != 16'd1) ? PH_TID : PH_DONE;
                end
              end
            endcase
          end
        end
        PH_DELTA: begin
          shift_d = vl;
          if (vdone) begin
            tick_d = tick_q + vl; shift_d = '0; phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (byte_i[7]) begin
            if (byte_i == ST_META) begin
              cur_d = byte_i; run_d = '0; phase_d = PH_MTYPE;
            end else if (byte_i == ST_SYSEX || byte_i == ST_ESCAPE) begin
              cur_d = byte_i; run_d = '0; phase_d = PH_SLEN;
            end else if (byte_i >= 8'hF0) begin
              r0.kind = EV_ERROR; r0.tick = tick_q; r0.err = ERR_STATUS; n = 2'd1;
              errs = 1'b1;
            end else begin
              cur_d = byte_i; run_d = byte_i; phase_d = PH_DATA1;
            end
          end else if (run_q == '0) begin
            r0.kind = EV_ERROR; r0.tick = tick_q; r0.err = ERR_RUNNING; n = 2'd1;
            errs = 1'b1;
          end else begin
            cur_d = run_q;
            if (one_data(run_q)) begin
              r0.kind = EV_CHAN; r0.tick = tick_q; r0.status = run_q; r0.d1 = byte_i;
              n = 2'd1; phase_d = PH_DELTA;
            end else begin
              held_d = byte_i; phase_d = PH_DATA2;
            end
          end
        end
        PH_DATA1: begin
          if (one_data(cur_q)) begin
            r0.kind = EV_CHAN; r0.tick = tick_q; r0.status = cur_q; r0.d1 = byte_i;
            n = 2'd1; phase_d = PH_DELTA;
          end else begin
            held_d = byte_i; phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          r0.kind = EV_CHAN; r0.tick = tick_q; r0.status = cur_q; r0.d1 = held_q;
          r0.d2 = byte_i; n = 2'd1; phase_d = PH_DELTA;
        end
        PH_MTYPE: begin
          held_d = byte_i; shift_d = '0; phase_d = PH_MLEN;
        end
        PH_MLEN, PH_SLEN: begin
          shift_d = vl;
          if (vdone) begin
            prem_d = vl[27:0]; shift_d = '0; n = 2'd1;
            r0.tick = tick_q; r0.len = vl;
            if (phase_q == PH_MLEN) begin
              r0.kind = EV_META; r0.status = ST_META; r0.d1 = held_q;
              phase_d = (vl != '0) ? PH_PAYLOAD : PH_DELTA;
            end else begin
              r0.kind = EV_SYSEX; r0.status = cur_q;
              if (vl != '0) phase_d = PH_PAYLOAD;
              else if (cur_q == ST_SYSEX) begin
                r1.kind = EV_ERROR; r1.tick = tick_q; r1.err = ERR_SYSEX; n = 2'd2;
                errs = 1'b1;
              end else phase_d = PH_DELTA;
            end
          end
        end
        PH_PAYLOAD: begin
          prem_d = prem_q - 28'd1;
          r0.kind = EV_PAYLOAD; r0.tick = tick_q; r0.status = cur_q; r0.d1 = byte_i;
          r0.plast = (prem_q == 28'd1); n = 2'd1;
          if (prem_q == 28'd1) begin
            if (cur_q == ST_SYSEX && byte_i != ST_ESCAPE) begin
              r1.kind = EV_ERROR; r1.tick = tick_q; r1.err = ERR_SYSEX; n = 2'd2;
              errs = 1'b1;
            end else phase_d = PH_DELTA;
          end
        end
        default: ;
      endcase
      // chunk byte count used up
      if (in_chunk && !errs && seen_inc == clen_q) begin
        if (n == 2'd0) begin
          r0.tick = tick_d;
          if (phase_d == PH_DELTA) r0.kind = EV_TEND;
          else begin
            r0.kind = EV_ERROR; r0.err = ERR_OVERRUN; errs = 1'b1;
          end
          n = 2'd1;
        end else begin
          r1.tick = tick_d;
          if (phase_d == PH_DELTA) r1.kind = EV_TEND;
          else begin
            r1.kind = EV_ERROR; r1.err = ERR_OVERRUN; errs = 1'b1;
          end
          n = 2'd2;
        end
        if (phase_d == PH_DELTA) begin
          trk_d = trk_q - 16'd1;
          phase_d = (trk_q != 16'd1) ? PH_TID : PH_DONE;
          shift_d = '0; cnt_d = '0;
        end
      end
      if (errs) err_d = 1'b1;
      r0.last = (n == 2'd1);
      r1.last = 1'b1;
    end else begin
      seen_d = seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HID; shift_q <= '0; cnt_q <= '0; clen_q <= '0; seen_q <= '0;
      tick_q <= '0; run_q <= '0; cur_q <= '0; held_q <= '0; prem_q <= '0;
      trk_q <= '0; err_q <= 1'b0;
    end else begin
      phase_q <= phase_d; shift_q <= shift_d; cnt_q <= cnt_d; clen_q <= clen_d;
      seen_q <= seen_d; tick_q <= tick_d; run_q <= run_d; cur_q <= cur_d;
      held_q <= held_d; prem_q <= prem_d; trk_q <= trk_d; err_q <= err_d;
    end
  end

  assign r0_o = r0;
  assign r1_o = r1;
  assign nres_o = n;
endmodule
`default_nettype wire

/* sv/mfbp_outq.sv */
// two-entry result register with push of up to two results and pop of one
`default_nettype none
module mfbp_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mfbp_pkg::result_t r0_i,
  input  wire mfbp_pkg::result_t r1_i,
  input  wire logic [1:0]        push_i,
  input  wire logic              pop_i,
  output mfbp_pkg::result_t      head_o,
  output logic [1:0]             count_o
);
  import mfbp_pkg::*;

  result_t    e_q [2];
  result_t    e_d [2];
  logic [1:0] cnt_q, cnt_d, base;

  always_comb begin
    e_d[0] = e_q[0]; e_d[1] = e_q[1];
    base = cnt_q;
    if (pop_i) begin
      e_d[0] = e_q[1];
      base = cnt_q - 2'd1;
    end
    if (push_i != 2'd0) begin
      if (base == 2'd0) begin
        e_d[0] = r0_i; e_d[1] = r1_i;
      end else e_d[1] = r0_i;
    end
    cnt_d = base + push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    e_q[0] <= e_d[0];
    e_q[1] <= e_d[1];
  end

  assign head_o = e_q[0];
  assign count_o = cnt_q;
endmodule
`default_nettype wire

/* sv/midi_file_byte_parser.sv */
// Standard MIDI File byte parser: one file byte per transfer, decoded combinationally
// into at most two results held in a two-entry output register. A byte is
// taken every cycle while the output register has room for two results; it stalls
// only when results are waiting downstream. After an error every byte is taken
// and dropped until reset.
`default_nettype none
module midi_file_byte_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        file_byte_valid_i,
  output logic             file_byte_stall_o,
  input  wire logic [7:0]  file_byte_i,
  output logic             result_valid_o,
  input  wire logic        result_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [31:0]      abs_tick_o,
  output logic [7:0]       status_byte_o,
  output logic [7:0]       first_data_o,
  output logic [7:0]       second_data_o,
  output logic [31:0]      length_value_o,
  output logic             file_format_o,
  output logic [15:0]      track_count_o,
  output logic [15:0]      division_o,
  output logic             payload_last_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);
  import mfbp_pkg::*;

  result_t    r0, r1, head;
  logic [1:0] nres, cnt;
  logic       take, pop;

  assign pop  = result_valid_o && !result_stall_i;
  // room for two after this cycle's pop
  assign file_byte_stall_o = (cnt == 2'd2) || (cnt == 2'd1 && !pop);
  assign take = file_byte_valid_i && !file_byte_stall_o;

  mfbp_core u_core (
    .clk_i, .rst_ni, .take_i(take), .byte_i(file_byte_i),
    .r0_o(r0), .r1_o(r1), .nres_o(nres)
  );

  mfbp_outq u_outq (
    .clk_i, .rst_ni, .r0_i(r0), .r1_i(r1), .push_i(nres), .pop_i(pop),
    .head_o(head), .count_o(cnt)
  );

  assign result_valid_o = cnt != 2'd0;
  assign event_kind_o   = head.kind;
  assign abs_tick_o     = head.tick;
  assign status_byte_o  = head.status;
  assign first_data_o   = head.d1;
  assign second_data_o  = head.d2;
  assign length_value_o = head.len;
  assign file_format_o  = head.fmt;
  assign track_count_o  = head.tracks;
  assign division_o     = head.division;
  assign payload_last_o = head.plast;
  assign error_code_o   = head.err;
  assign last_o         = head.last;
endmodule
`default_nettype wire

/* sv/midi_file_byte_parser_checker.sv */
// port-level checks for the midi file byte parser
`default_nettype none
module midi_file_byte_parser_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       file_byte_stall_o,
  input wire logic       result_valid_o,
  input wire logic       result_stall_i,
  input wire logic [2:0] event_kind_o,
  input wire logic [3:0] error_code_o,
  input wire logic       payload_last_o
);
  import mfbp_pkg::*;

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && event_kind_o == EV_ERROR |-> error_code_o != ERR_NONE)
    else $error("error result without code");
  a_code_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && event_kind_o != EV_ERROR |-> error_code_o == ERR_NONE)
    else $error("code on non-error result");
  a_plast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && payload_last_o |-> event_kind_o == EV_PAYLOAD)
    else $error("payload last on wrong kind");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(event_kind_o))
    else $error("stalled result changed");
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !file_byte_stall_o)
    else $error("stall with empty output");
endmodule

bind midi_file_byte_parser midi_file_byte_parser_checker u_checker (
  .clk_i, .rst_ni, .file_byte_stall_o, .result_valid_o,
  .result_stall_i, .event_kind_o, .error_code_o, .payload_last_o
);
`default_nettype wire

/* bench/tb_top.sv */
// testbench for the midi file byte parser: directed header, predicted random tracks, closing error
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mfbp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        file_byte_valid_i = 1'b0;
  logic        file_byte_stall_o;
  logic [7:0]  file_byte_i = 8'h00;
  logic        result_valid_o;
  logic        result_stall_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [31:0] abs_tick_o;
  logic [7:0]  status_byte_o;
  logic [7:0]  first_data_o;
  logic [7:0]  second_data_o;
  logic [31:0] length_value_o;
  logic        file_format_o;
  logic [15:0] track_count_o;
  logic [15:0] division_o;
  logic        payload_last_o;
  logic [3:0]  error_code_o;
  logic        last_o;

  midi_file_byte_parser u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // parser state mirror
  phase_e      ph;
  logic [31:0] shf, clen, cseen, tick;
  logic [2:0]  fcnt;
  logic [7:0]  run_st, cur_st, held;
  logic [27:0] prem;
  logic [15:0] trem;
  logic        errl;
  result_t     step_q[$];
  result_t     event_q[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  bytes_sent = 0;
  bit  quiet = 1'b0;
  bit  started = 1'b0;

  function automatic result_t mk(logic [2:0] k, logic [31:0] t, logic [7:0] st, logic [7:0] a,
                                 logic [7:0] b, logic [31:0] len, logic pl, logic [3:0] e);
    result_t r;
    r = '0;
    r.kind = k; r.tick = t; r.status = st; r.d1 = a; r.d2 = b;
    r.len = len; r.plast = pl; r.err = e;
    return r;
  endfunction

  function automatic bit takes_one(logic [7:0] st);
    return st[6:4] == 3'd4 || st[6:4] == 3'd5;
  endfunction

  function automatic bit fixed_done(logic [7:0] b, int n);
    shf = {shf[23:0], b};
    fcnt = fcnt + 3'd1;
    return fcnt >= n;
  endfunction

  function automatic bit vlq_done(logic [7:0] b);
    shf = {shf[24:0], b[6:0]} & 32'h0FFF_FFFF;
    return !b[7];
  endfunction

  task automatic raise_error(logic [3:0] code);
    step_q.push_back(mk(EV_ERROR, tick, 8'h00, 8'h00, 8'h00, '0, 1'b0, code));
    errl = 1'b1;
  endtask

  task automatic close_track();
    step_q.push_back(mk(EV_TEND, tick, 8'h00, 8'h00, 8'h00, '0, 1'b0, ERR_NONE));
    trem = trem - 16'd1;
    ph = (trem != 0) ? PH_TID : PH_DONE;
    shf = '0; fcnt = '0;
  endtask

  task automatic parse_reset();
    ph = PH_HID; shf = '0; fcnt = '0; clen = '0; cseen = '0; tick = '0;
    run_st = '0; cur_st = '0; held = '0; prem = '0; trem = '0; errl = 1'b0;
  endtask

  // works out the results of one file byte into step_q
  task automatic parse_byte(logic [7:0] b);
    logic [31:0] v;
    bit in_chunk;
    step_q.delete();
    if (errl) return;
    in_chunk = ph >= PH_DELTA && ph <= PH_PAYLOAD;
    if (in_chunk) cseen = cseen + 1;
    case (ph)
      PH_HID, PH_TID: begin
        if (fixed_done(b, 4)) begin
          v = shf; shf = '0; fcnt = '0;
          if (ph == PH_HID) begin
            if (v != ID_HEADER) raise_error(ERR_MTHD); else ph = PH_HLEN;
          end else begin
            if (v != ID_TRACK) raise_error(ERR_MTRK); else ph = PH_TLEN;
          end
        end
      end
      PH_HLEN: begin
        if (fixed_done(b, 4)) begin
          v = shf; shf = '0; fcnt = '0;
          if (v != 32'd6) raise_error(ERR_HLEN); else ph = PH_HFMT;
        end
      end
      PH_HFMT: begin
        if (fixed_done(b, 2)) begin
          v = shf & 32'hFFFF; shf = '0; fcnt = '0;
          if (v > 1) raise_error(ERR_FORMAT);
          else begin
            held = v[7:0]; ph = PH_HREST;
          end
        end
      end
      PH_HREST: begin
        if (fixed_done(b, 4)) begin
          v = shf; shf = '0; fcnt = '0;
          trem = v[31:16];
          step_q.push_back(mk(EV_HEADER, '0, 8'h00, 8'h00, 8'h00, '0, 1'b0, ERR_NONE));
          step_q[0].fmt = held[0];
          step_q[0].tracks = v[31:16];
          step_q[0].division = v[15:0];
          held = '0;
          ph = (trem != 0) ? PH_TID : PH_DONE;
        end
      end
      PH_TLEN: begin
        if (fixed_done(b, 4)) begin
          clen = shf; shf = '0; fcnt = '0;
          cseen = '0; tick = '0; run_st = '0;
          step_q.push_back(mk(EV_TSTART, '0, 8'h00, 8'h00, 8'h00, clen, 1'b0, ERR_NONE));
          ph = PH_DELTA;
          if (clen == 0) close_track();
        end
      end
      PH_DELTA: begin
        if (vlq_done(b)) begin
          tick = tick + shf; shf = '0; ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (b == ST_META) begin
            cur_st = b; run_st = '0; ph = PH_MTYPE;
          end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
            cur_st = b; run_st = '0; ph = PH_SLEN;
          end else if (b >= 8'hF0) begin
            raise_error(ERR_STATUS);
          end else begin
            cur_st = b; run_st = b; ph = PH_DATA1;
          end
        end else if (run_st == 0) begin
          raise_error(ERR_RUNNING);
        end else begin
          cur_st = run_st;
          if (takes_one(cur_st)) begin
            step_q.push_back(mk(EV_CHAN, tick, cur_st, b, 8'h00, '0, 1'b0, ERR_NONE));
            ph = PH_DELTA;
          end else begin
            held = b; ph = PH_DATA2;
          end
        end
      end
      PH_DATA1: begin
        if (takes_one(cur_st)) begin
          step_q.push_back(mk(EV_CHAN, tick, cur_st, b, 8'h00, '0, 1'b0, ERR_NONE));
          ph = PH_DELTA;
        end else begin
          held = b; ph = PH_DATA2;
        end
      end
      PH_DATA2: begin
        step_q.push_back(mk(EV_CHAN, tick, cur_st, held, b, '0, 1'b0, ERR_NONE));
        ph = PH_DELTA;
      end
      PH_MTYPE: begin
        held = b; shf = '0; ph = PH_MLEN;
      end
      PH_MLEN: begin
        if (vlq_done(b)) begin
          prem = shf[27:0]; shf = '0;
          step_q.push_back(mk(EV_META, tick, ST_META, held, 8'h00, {4'h0, prem}, 1'b0,
                              ERR_NONE));
          ph = (prem != 0) ? PH_PAYLOAD : PH_DELTA;
        end
      end
      PH_SLEN: begin
        if (vlq_done(b)) begin
          prem = shf[27:0]; shf = '0;
          step_q.push_back(mk(EV_SYSEX, tick, cur_st, 8'h00, 8'h00, {4'h0, prem}, 1'b0,
                              ERR_NONE));
          if (prem != 0) ph = PH_PAYLOAD;
          else if (cur_st == ST_SYSEX) raise_error(ERR_SYSEX);
          else ph = PH_DELTA;
        end
      end
      PH_PAYLOAD: begin
        prem = prem - 28'd1;
        step_q.push_back(mk(EV_PAYLOAD, tick, cur_st, b, 8'h00, '0, prem == 0, ERR_NONE));
        if (prem == 0) begin
          if (cur_st == ST_SYSEX && b != ST_ESCAPE) raise_error(ERR_SYSEX);
          else ph = PH_DELTA;
        end
      end
      default: ;
    endcase
    if (in_chunk && !errl && cseen == clen) begin
      if (ph == PH_DELTA) close_track();
      else raise_error(ERR_OVERRUN);
    end
    foreach (step_q[i]) step_q[i].last = (i == step_q.size() - 1);
  endtask

  // one byte transfer; typed expectation replaces the predicted one when given
  task automatic send_byte(logic [7:0] b, bit typed = 1'b0, result_t want = '0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      file_byte_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    file_byte_valid_i = 1'b1;
    file_byte_i = b;
    do @(posedge clk_i); while (file_byte_stall_o);
    parse_byte(b);
    if (typed) event_q.push_back(want);
    else foreach (step_q[i]) event_q.push_back(step_q[i]);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  logic [7:0] trk_q[$];
  logic [7:0] gen_run;

  task automatic push_vlq(logic [27:0] val, bit pad);
    logic [7:0] grp[$];
    grp.push_front({1'b0, val[6:0]});
    val = val >> 7;
    while (val != 0) begin
      grp.push_front({1'b1, val[6:0]});
      val = val >> 7;
    end
    if (pad) trk_q.push_back(8'h80);
    foreach (grp[i]) trk_q.push_back(grp[i]);
  endtask

  task automatic push_delta();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) trk_q.push_back(8'($urandom_range(0, 127)));
    else if (r < 17) push_vlq(28'($urandom_range(0, 32'h3FFF)), $urandom_range(0, 3) == 0);
    else if (r < 19) push_vlq(28'($urandom), 1'b0);
    else push_vlq(28'hFFF_FFFF, 1'b0);
  endtask

  task automatic push_event();
    logic [7:0] st;
    int n;
    push_delta();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        st = 8'($urandom_range(8'h80, 8'hEF));
        gen_run = st;
        trk_q.push_back(st);
        trk_q.push_back(8'($urandom_range(0, 255)));
        if (!takes_one(st)) trk_q.push_back(8'($urandom_range(0, 255)));
      end
      4, 5: begin
        if (gen_run == 0) begin
          gen_run = 8'($urandom_range(8'h80, 8'hEF));
          trk_q.push_back(gen_run);
        end
        trk_q.push_back(8'($urandom_range(0, 127)));
        if (!takes_one(gen_run)) trk_q.push_back(8'($urandom_range(0, 255)));
      end
      6, 7: begin
        n = $urandom_range(0, 5);
        gen_run = 8'h00;
        trk_q.push_back(ST_META);
        trk_q.push_back(8'($urandom_range(0, 255)));
        push_vlq(28'(n), $urandom_range(0, 4) == 0);
        repeat (n) trk_q.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        n = $urandom_range(1, 5);
        gen_run = 8'h00;
        trk_q.push_back(ST_SYSEX);
        push_vlq(28'(n), $urandom_range(0, 4) == 0);
        repeat (n - 1) trk_q.push_back(8'($urandom_range(0, 255)));
        trk_q.push_back(ST_ESCAPE);
      end
      default: begin
        n = $urandom_range(0, 4);
        gen_run = 8'h00;
        trk_q.push_back(ST_ESCAPE);
        push_vlq(28'(n), 1'b0);
        repeat (n) trk_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic send_chunk(logic [31:0] len);
    send_byte(8'h4D); send_byte(8'h54); send_byte(8'h72); send_byte(8'h6B);
    send_byte(len[31:24]); send_byte(len[23:16]); send_byte(len[15:8]); send_byte(len[7:0]);
    foreach (trk_q[i]) send_byte(trk_q[i]);
  endtask

  typedef struct {
    logic [7:0] val;
    bit         typed;
    result_t    want;
  } stim_row_t;

  stim_row_t dir_rows[$];

  task automatic add_row(logic [7:0] v, bit typed = 1'b0, result_t want = '0);
    stim_row_t r;
    r.val = v; r.typed = typed; r.want = want;
    dir_rows.push_back(r);
  endtask

  // result side: random stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall_i = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        result_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (result_valid_o && !result_stall_i) begin
      got = '0;
      got.kind = event_kind_o; got.tick = abs_tick_o; got.status = status_byte_o;
      got.d1 = first_data_o; got.d2 = second_data_o; got.len = length_value_o;
      got.fmt = file_format_o; got.tracks = track_count_o; got.division = division_o;
      got.plast = payload_last_o; got.err = error_code_o; got.last = last_o;
      if (event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = event_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if (started) begin
      if ((file_byte_valid_i && !file_byte_stall_o) || (result_valid_o && !result_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    result_t hdr;
    int target;
    parse_reset();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    started = 1'b1;

    // header at its extremes: format 1, all tracks, full division
    hdr = mk(EV_HEADER, '0, 8'h00, 8'h00, 8'h00, '0, 1'b0, ERR_NONE);
    hdr.fmt = 1'b1; hdr.tracks = 16'hFFFF; hdr.division = 16'hFFFF; hdr.last = 1'b1;
    add_row(8'h4D); add_row(8'h54); add_row(8'h68); add_row(8'h64);
    add_row(8'h00); add_row(8'h00); add_row(8'h00); add_row(8'h06);
    add_row(8'h00); add_row(8'h01);
    add_row(8'hFF); add_row(8'hFF); add_row(8'hFF); add_row(8'hFF, 1'b1, hdr);
    // zero-length track: start and end on one byte
    add_row(8'h4D); add_row(8'h54); add_row(8'h72); add_row(8'h6B);
    add_row(8'h00); add_row(8'h00); add_row(8'h00); add_row(8'h00);
    foreach (dir_rows[i]) send_byte(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);

    // random well-formed tracks
    while (bytes_sent < 1150) begin
      if (bytes_sent > 980) quiet = 1'b1;
      trk_q.delete();
      gen_run = 8'h00;
      target = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(4, 60);
      while (trk_q.size() < target) push_event();
      send_chunk(trk_q.size());
      if (bytes_sent > 500 && bytes_sent < 600) begin
        file_byte_valid_i = 1'b0;
        while (event_q.size() != 0) @(negedge clk_i);
      end
    end

    // one error to close the file, then bytes that must be dropped
    trk_q.delete();
    gen_run = 8'h00;
    case ($urandom_range(0, 5))
      0: begin
        repeat (3) push_event();
        send_chunk(trk_q.size() - 1);
      end
      1: begin
        trk_q = '{8'h00, 8'hF3};
        send_chunk(100);
      end
      2: begin
        trk_q = '{8'h00, 8'h40};
        send_chunk(100);
      end
      3: begin
        trk_q = '{8'h00, 8'hF0, 8'h02, 8'h11, 8'h22};
        send_chunk(100);
      end
      4: begin
        trk_q = '{8'h00, 8'hF0, 8'h00};
        send_chunk(100);
      end
      default: begin
        send_byte(8'h4D); send_byte(8'h54); send_byte(8'h72); send_byte(8'h6C);
      end
    endcase
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    file_byte_valid_i = 1'b0;

    while (event_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
